FILE: hw/rtl/wpfm_pkg.sv
// ----------------------------------------------------------------------------
// wpfm_pkg
// Shared widths, limits and status codes of the windowed pulse frequency meter.
// ----------------------------------------------------------------------------
package wpfm_pkg;

    localparam int CNT_W   = 32;
    localparam int BIT_W   = 5;
    localparam int PROD_W  = 27;
    localparam int DIV_W   = 11;
    localparam int QUOT_W  = 17;
    localparam int HZ_W    = 15;
    localparam int ST_W    = 3;
    localparam int TGT_W   = 16;
    localparam int SEL_W   = 8;
    localparam int CFG_W   = 16;

    localparam logic [TGT_W:0]    REGISTER_COUNT = 17'd256;
    localparam logic [SEL_W-1:0]  ONLY_COUNTER   = 8'd4;

    localparam logic [CNT_W-1:0]  WIN_LO_M1_MS   = 32'd999;
    localparam logic [CNT_W-1:0]  WIN_HI_MS      = 32'd2000;
    localparam logic [CNT_W-1:0]  STALE_MS       = 32'd5000;
    localparam logic [CNT_W-1:0]  MAX_DELTA      = 32'd100000;
    localparam logic [QUOT_W-1:0] MAX_HZ         = 17'd20000;

    localparam logic [ST_W-1:0] STATUS_PRIMED   = 3'd0;
    localparam logic [ST_W-1:0] STATUS_CNTRESET = 3'd1;
    localparam logic [ST_W-1:0] STATUS_MEASURED = 3'd2;
    localparam logic [ST_W-1:0] STATUS_ANOMALY  = 3'd3;
    localparam logic [ST_W-1:0] STATUS_TIMEOUT  = 3'd4;
    localparam logic [ST_W-1:0] STATUS_WAITING  = 3'd5;
    localparam logic [ST_W-1:0] STATUS_REJECTED = 3'd6;

    localparam logic CFG_TARGET  = 1'b0;
    localparam logic CFG_COUNTER = 1'b1;

endpackage

FILE: hw/rtl/wpfm_divider.sv
// ----------------------------------------------------------------------------
// wpfm_divider
// Restoring divider, one quotient bit per cycle, 27-bit dividend by 11 bits.
// ----------------------------------------------------------------------------
module wpfm_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wpfm_pkg::PROD_W-1:0]  dividend,
    input  logic [wpfm_pkg::DIV_W-1:0]   divisor,
    output logic                         done,
    output logic [wpfm_pkg::QUOT_W-1:0]  quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [wpfm_pkg::BIT_W-1:0]   step_reg;
    logic [wpfm_pkg::PROD_W-1:0]  dvd_reg;
    logic [wpfm_pkg::DIV_W-1:0]   dsr_reg;
    logic [wpfm_pkg::DIV_W-1:0]   rem_reg;
    logic [wpfm_pkg::QUOT_W-1:0]  quot_reg;

    logic [wpfm_pkg::DIV_W:0]     trial;
    logic                         fits;
    logic [wpfm_pkg::DIV_W:0]     diff;

    assign trial = {rem_reg, dvd_reg[wpfm_pkg::PROD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == wpfm_pkg::BIT_W'(wpfm_pkg::PROD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[wpfm_pkg::PROD_W-2:0], 1'b0};
            rem_reg  <= fits ? diff[wpfm_pkg::DIV_W-1:0] : trial[wpfm_pkg::DIV_W-1:0];
            quot_reg <= {quot_reg[wpfm_pkg::QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: hw/rtl/windowed_pulse_frequency_meter.sv
// ----------------------------------------------------------------------------
// windowed_pulse_frequency_meter
// Gated frequency counter over count and millisecond snapshots, bit-serial.
// Flow: a rejected or priming transaction goes straight to the output state;
//   the other non-measuring cases first run the serial subtract and compare
//   and the decision state; a measurement adds a serial multiply by 1000 and a divide.
// Throughput: one transaction at a time, held in the output state while m_tready
//   stalls; s_tready returns when the result moves to the output register.
// Reset: synchronous active-low aresetn clears tracking and the primed flag.
// ----------------------------------------------------------------------------
module windowed_pulse_frequency_meter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [wpfm_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,  // pulse_count[31:0], now_ms[63:32]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata   // write_enable[0], frequency_hz[15:1],
                                                  // status[18:16], zero[23:19]
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUB    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                        state_reg;
    logic [wpfm_pkg::TGT_W-1:0]        target_reg;
    logic [wpfm_pkg::SEL_W-1:0]        select_reg;
    logic                              primed_reg;
    logic [wpfm_pkg::CNT_W-1:0]        last_cnt_reg;
    logic [wpfm_pkg::CNT_W-1:0]        last_time_reg;
    logic [wpfm_pkg::CNT_W-1:0]        cnt_sr_reg;
    logic [wpfm_pkg::CNT_W-1:0]        now_sr_reg;
    logic [wpfm_pkg::CNT_W-1:0]        delta_sr_reg;
    logic [wpfm_pkg::CNT_W-1:0]        elapsed_sr_reg;
    logic [wpfm_pkg::PROD_W-1:0]       prod_sr_reg;
    logic [9:0]                        dly_reg;
    logic [1:0]                        br_reg;
    logic [wpfm_pkg::BIT_W-1:0]        bit_reg;
    logic                              bor_d_reg;
    logic                              bor_t_reg;
    logic                              lo_gt_reg;
    logic                              hi_gt_reg;
    logic                              stale_gt_reg;
    logic                              max_gt_reg;
    logic                              div_start_reg;
    logic                              res_we_reg;
    logic [wpfm_pkg::HZ_W-1:0]         res_hz_reg;
    logic [wpfm_pkg::ST_W-1:0]         res_st_reg;
    logic                              m_tvalid_reg;
    logic [23:0]                       m_tdata_reg;

    logic                              rejected;
    logic                              s_fire;
    logic                              out_load;
    logic                              a_c, b_c, a_t, b_t;
    logic                              d_bit, e_bit;
    logic                              bor_d_next, bor_t_next;
    logic [2:0]                        sub_sum;
    logic                              p_bit;
    logic [3:0]                        br_tmp;
    logic [1:0]                        br_next;
    logic                              div_done;
    logic [wpfm_pkg::QUOT_W-1:0]       div_quot;
    logic [wpfm_pkg::HZ_W-1:0]         hz_sat;

    assign rejected = ({1'b0, target_reg} >= wpfm_pkg::REGISTER_COUNT) ||
                      (select_reg != wpfm_pkg::ONLY_COUNTER);
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign a_c        = cnt_sr_reg[0];
    assign b_c        = last_cnt_reg[0];
    assign a_t        = now_sr_reg[0];
    assign b_t        = last_time_reg[0];
    assign d_bit      = a_c ^ b_c ^ bor_d_reg;
    assign e_bit      = a_t ^ b_t ^ bor_t_reg;
    assign bor_d_next = (~a_c & (b_c | bor_d_reg)) | (b_c & bor_d_reg);
    assign bor_t_next = (~a_t & (b_t | bor_t_reg)) | (b_t & bor_t_reg);

    // delta*1000 as (delta << 10) - (delta << 4) - (delta << 3), LSB first
    assign sub_sum = {2'b0, dly_reg[3]} + {2'b0, dly_reg[2]} + {1'b0, br_reg};
    assign p_bit   = dly_reg[9] ^ sub_sum[0];
    assign br_tmp  = {1'b0, sub_sum} + {3'b0, p_bit} - {3'b0, dly_reg[9]};
    assign br_next = br_tmp[2:1];

    assign hz_sat = (div_quot > wpfm_pkg::MAX_HZ) ? wpfm_pkg::MAX_HZ[wpfm_pkg::HZ_W-1:0]
                                                  : div_quot[wpfm_pkg::HZ_W-1:0];

    wpfm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (prod_sr_reg),
        .divisor  (elapsed_sr_reg[wpfm_pkg::DIV_W-1:0]),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            select_reg <= wpfm_pkg::ONLY_COUNTER;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                wpfm_pkg::CFG_TARGET:  target_reg <= cfg_wdata;
                wpfm_pkg::CFG_COUNTER: select_reg <= cfg_wdata[wpfm_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            primed_reg    <= 1'b0;
            last_cnt_reg  <= '0;
            last_time_reg <= '0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (rejected) begin
                            res_we_reg <= 1'b0;
                            res_hz_reg <= '0;
                            res_st_reg <= wpfm_pkg::STATUS_REJECTED;
                            state_reg  <= S_OUT;
                        end else if (!primed_reg) begin
                            last_cnt_reg  <= s_tdata[31:0];
                            last_time_reg <= s_tdata[63:32];
                            primed_reg    <= 1'b1;
                            res_we_reg    <= 1'b1;
                            res_hz_reg    <= '0;
                            res_st_reg    <= wpfm_pkg::STATUS_PRIMED;
                            state_reg     <= S_OUT;
                        end else begin
                            cnt_sr_reg   <= s_tdata[31:0];
                            now_sr_reg   <= s_tdata[63:32];
                            bor_d_reg    <= 1'b0;
                            bor_t_reg    <= 1'b0;
                            lo_gt_reg    <= 1'b0;
                            hi_gt_reg    <= 1'b0;
                            stale_gt_reg <= 1'b0;
                            max_gt_reg   <= 1'b0;
                            bit_reg      <= '0;
                            state_reg    <= S_SUB;
                        end
                    end
                end
                S_SUB: begin
                    cnt_sr_reg     <= {cnt_sr_reg[0], cnt_sr_reg[wpfm_pkg::CNT_W-1:1]};
                    now_sr_reg     <= {now_sr_reg[0], now_sr_reg[wpfm_pkg::CNT_W-1:1]};
                    last_cnt_reg   <= {last_cnt_reg[0], last_cnt_reg[wpfm_pkg::CNT_W-1:1]};
                    last_time_reg  <= {last_time_reg[0], last_time_reg[wpfm_pkg::CNT_W-1:1]};
                    delta_sr_reg   <= {d_bit, delta_sr_reg[wpfm_pkg::CNT_W-1:1]};
                    elapsed_sr_reg <= {e_bit, elapsed_sr_reg[wpfm_pkg::CNT_W-1:1]};
                    bor_d_reg      <= bor_d_next;
                    bor_t_reg      <= bor_t_next;
                    if (e_bit != wpfm_pkg::WIN_LO_M1_MS[bit_reg]) lo_gt_reg <= e_bit;
                    if (e_bit != wpfm_pkg::WIN_HI_MS[bit_reg]) hi_gt_reg <= e_bit;
                    if (e_bit != wpfm_pkg::STALE_MS[bit_reg]) stale_gt_reg <= e_bit;
                    if (d_bit != wpfm_pkg::MAX_DELTA[bit_reg]) max_gt_reg <= d_bit;
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == wpfm_pkg::BIT_W'(wpfm_pkg::CNT_W - 1)) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    res_hz_reg <= '0;
                    if (bor_d_reg) begin
                        last_cnt_reg  <= cnt_sr_reg;
                        last_time_reg <= now_sr_reg;
                        res_we_reg    <= 1'b1;
                        res_st_reg    <= wpfm_pkg::STATUS_CNTRESET;
                        state_reg     <= S_OUT;
                    end else if (lo_gt_reg && !hi_gt_reg) begin
                        last_cnt_reg  <= cnt_sr_reg;
                        last_time_reg <= now_sr_reg;
                        if (max_gt_reg) begin
                            res_we_reg <= 1'b0;
                            res_st_reg <= wpfm_pkg::STATUS_ANOMALY;
                            state_reg  <= S_OUT;
                        end else begin
                            dly_reg   <= '0;
                            br_reg    <= '0;
                            bit_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                    end else if (stale_gt_reg) begin
                        last_cnt_reg  <= cnt_sr_reg;
                        last_time_reg <= now_sr_reg;
                        res_we_reg    <= 1'b1;
                        res_st_reg    <= wpfm_pkg::STATUS_TIMEOUT;
                        state_reg     <= S_OUT;
                    end else begin
                        res_we_reg <= 1'b0;
                        res_st_reg <= wpfm_pkg::STATUS_WAITING;
                        state_reg  <= S_OUT;
                    end
                end
                S_MUL: begin
                    delta_sr_reg <= {1'b0, delta_sr_reg[wpfm_pkg::CNT_W-1:1]};
                    dly_reg      <= {dly_reg[8:0], delta_sr_reg[0]};
                    br_reg       <= br_next;
                    prod_sr_reg  <= {p_bit, prod_sr_reg[wpfm_pkg::PROD_W-1:1]};
                    bit_reg      <= bit_reg + 1'b1;
                    if (bit_reg == wpfm_pkg::BIT_W'(wpfm_pkg::PROD_W - 1)) begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        res_we_reg <= 1'b1;
                        res_hz_reg <= hz_sat;
                        res_st_reg <= wpfm_pkg::STATUS_MEASURED;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {5'b0, res_st_reg, res_hz_reg, res_we_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_reject_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && rejected) |=>
            (state_reg == S_OUT && res_st_reg == wpfm_pkg::STATUS_REJECTED))
        else $error("rejected transaction did not report rejection");

    a_hz_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (res_hz_reg <= wpfm_pkg::MAX_HZ[wpfm_pkg::HZ_W-1:0]))
        else $error("frequency above saturation limit");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !res_we_reg) |-> (res_hz_reg == '0))
        else $error("nonzero frequency without write");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide phase");

    a_prime_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !rejected && primed_reg) |=> (state_reg == S_SUB))
        else $error("primed transaction skipped serial compare");

endmodule

FILE: tb/windowed_pulse_frequency_meter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_pulse_frequency_meter_tb
// Drives count/time snapshots through the meter under random sender bursts
// and receiver stalls. A scoreboard class keeps its own copy of the tracking
// state and configuration, predicts each reading and checks it field by field.
// ----------------------------------------------------------------------------
module windowed_pulse_frequency_meter_tb;

    localparam int          CLK_HALF_NS  = 10;
    localparam int          RESET_CYCLES = 12;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          LONG_HOLD_CYCLES = 600;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned SCALE_MS     = 1000;

    typedef struct packed {
        logic [4:0]                pad;
        logic [wpfm_pkg::ST_W-1:0] status;
        logic [wpfm_pkg::HZ_W-1:0] hz;
        logic                      we;
    } meter_reading_t;

    class freq_meter_scoreboard;
        logic [wpfm_pkg::TGT_W-1:0] target_reg;
        logic [wpfm_pkg::SEL_W-1:0] counter_sel;
        logic [wpfm_pkg::CNT_W-1:0] last_count;
        logic [wpfm_pkg::CNT_W-1:0] last_time_ms;
        bit                         primed;
        meter_reading_t             expected_readings[$];
        int                         errors;

        function new();
            target_reg   = '0;
            counter_sel  = wpfm_pkg::ONLY_COUNTER;
            last_count   = '0;
            last_time_ms = '0;
            primed       = 1'b0;
            errors       = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(input logic addr, input logic [wpfm_pkg::CFG_W-1:0] value);
            if (addr == wpfm_pkg::CFG_TARGET) begin
                target_reg = value[wpfm_pkg::TGT_W-1:0];
            end else begin
                counter_sel = value[wpfm_pkg::SEL_W-1:0];
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_update(input logic [63:0] item);
            logic [wpfm_pkg::CNT_W-1:0] cnt;
            logic [wpfm_pkg::CNT_W-1:0] now;
            logic [wpfm_pkg::CNT_W-1:0] elapsed;
            logic [wpfm_pkg::CNT_W-1:0] delta;
            logic [63:0]                scaled;
            meter_reading_t             r;
            cnt = item[31:0];
            now = item[63:32];
            r   = '{pad: '0, status: wpfm_pkg::STATUS_WAITING, hz: '0, we: 1'b0};
            if ({1'b0, target_reg} >= wpfm_pkg::REGISTER_COUNT ||
                counter_sel != wpfm_pkg::ONLY_COUNTER) begin
                r.status = wpfm_pkg::STATUS_REJECTED;
            end else if (!primed) begin
                last_count   = cnt;
                last_time_ms = now;
                primed       = 1'b1;
                r.we         = 1'b1;
                r.status     = wpfm_pkg::STATUS_PRIMED;
            end else begin
                elapsed = now - last_time_ms;
                if (cnt < last_count) begin
                    last_count   = cnt;
                    last_time_ms = now;
                    r.we         = 1'b1;
                    r.status     = wpfm_pkg::STATUS_CNTRESET;
                end else if (elapsed > wpfm_pkg::WIN_LO_M1_MS &&
                             elapsed <= wpfm_pkg::WIN_HI_MS) begin
                    delta        = cnt - last_count;
                    last_count   = cnt;
                    last_time_ms = now;
                    if (delta > wpfm_pkg::MAX_DELTA) begin
                        r.status = wpfm_pkg::STATUS_ANOMALY;
                    end else begin
                        scaled = (64'(delta) * SCALE_MS) / 64'(elapsed);
                        if (scaled > 64'(wpfm_pkg::MAX_HZ)) begin
                            scaled = 64'(wpfm_pkg::MAX_HZ);
                        end
                        r.we     = 1'b1;
                        r.hz     = scaled[wpfm_pkg::HZ_W-1:0];
                        r.status = wpfm_pkg::STATUS_MEASURED;
                    end
                end else if (elapsed > wpfm_pkg::STALE_MS) begin
                    last_count   = cnt;
                    last_time_ms = now;
                    r.we         = 1'b1;
                    r.status     = wpfm_pkg::STATUS_TIMEOUT;
                end
            end
            expected_readings.push_back(r);
        endfunction

        task check_reading(input logic [23:0] tdata);
            meter_reading_t got;
            meter_reading_t exp_r;
            got = tdata;
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected reading %h", tdata));
            end else begin
                exp_r = expected_readings.pop_front();
                if (got.we !== exp_r.we) begin
                    report_mismatch($sformatf("write_enable %b, expected %b", got.we, exp_r.we));
                end
                if (got.hz !== exp_r.hz) begin
                    report_mismatch($sformatf("frequency_hz %0d, expected %0d",
                                              got.hz, exp_r.hz));
                end
                if (got.status !== exp_r.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, exp_r.status));
                end
                if (got.pad !== '0) begin
                    report_mismatch($sformatf("fill bits %b not zero", got.pad));
                end
            end
        endtask
    endclass

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic                         cfg_addr  = wpfm_pkg::CFG_TARGET;
    logic [wpfm_pkg::CFG_W-1:0]   cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [63:0]                  s_tdata   = '0;    // pulse_count[31:0], now_ms[63:32]
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [23:0]                  m_tdata;           // write_enable[0], frequency_hz[15:1],
                                                     // status[18:16], zero[23:19]

    freq_meter_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    int unsigned long_hold_at = 0;
    bit          long_hold_done = 1'b0;
    int          hold_left   = 0;
    int          pattern_age = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    windowed_pulse_frequency_meter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_reading(m_tdata);
        end
    end

    // Stall the result side on a rotating pattern; hold off once for a long stretch.
    always @(posedge aclk) begin
        if (!long_hold_done && long_hold_at != 0 && cycle_count >= long_hold_at) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                pattern_age = $urandom_range(16, 96);
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
            end
            pattern_age--;
            m_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    task automatic send_update(input logic [31:0] cnt, input logic [31:0] now);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
        end
        burst_left--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, cnt};
        do @(posedge aclk); while (!s_tready);
        sb.note_update({now, cnt});
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [wpfm_pkg::TGT_W-1:0] tgt,
                              input logic [wpfm_pkg::SEL_W-1:0] sel);
        cfg_we    <= 1'b1;
        cfg_addr  <= wpfm_pkg::CFG_TARGET;
        cfg_wdata <= tgt;
        @(posedge aclk);
        sb.write_reg(wpfm_pkg::CFG_TARGET, tgt);
        cfg_addr  <= wpfm_pkg::CFG_COUNTER;
        cfg_wdata <= {8'($urandom()), sel};
        @(posedge aclk);
        sb.write_reg(wpfm_pkg::CFG_COUNTER, cfg_wdata);
        cfg_we    <= 1'b0;
    endtask

    // Shape each update around the last recorded snapshot.
    task automatic send_random_update();
        logic [31:0] cnt;
        logic [31:0] now;
        int unsigned pick;
        cnt  = sb.last_count;
        now  = sb.last_time_ms;
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            now += $urandom_range(1000, 2000);
            case ($urandom_range(0, 9)) inside
                [0:6]:   cnt += $urandom_range(0, 25000);
                7:       cnt += $urandom_range(0, 100000);
                8:       cnt += $urandom_range(99990, 100010);
                default: cnt += $urandom_range(100001, 32'hFFFF_FFFF);
            endcase
        end else if (pick < 68) begin
            now += $urandom_range(0, 999);
            cnt += $urandom_range(0, 5000);
        end else if (pick < 75) begin
            now += $urandom_range(2001, 5000);
            cnt += $urandom_range(0, 50000);
        end else if (pick < 82) begin
            now += $urandom_range(5001, 32'hFFFF_FFFF);
            cnt += $urandom_range(0, 1000000);
        end else if (pick < 88 && cnt != 0) begin
            cnt -= $urandom_range(1, cnt);
            now += $urandom_range(0, 3000);
        end else begin
            cnt = $urandom();
            now = $urandom();
        end
        send_update(cnt, now);
    endtask

    task automatic run_random(input int n_items);
        repeat (n_items) send_random_update();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(16'd0, wpfm_pkg::ONLY_COUNTER);
        send_update(32'd0,          32'd0);
        send_update(32'd10,         32'd500);
        send_update(32'd100,        32'd999);
        send_update(32'd1000,       32'd1000);
        send_update(32'd41000,      32'd3000);
        send_update(32'd141000,     32'd4001);
        send_update(32'd241001,     32'd5001);
        send_update(32'd241001,     32'd7002);
        send_update(32'd241001,     32'd10001);
        send_update(32'd241001,     32'd10002);
        send_update(32'd241000,     32'd10003);
        send_update(32'd241000,     32'hFFFF_FE00);
        send_update(32'd241000,     32'h0000_03DC);
        send_update(32'hFFFF_FFFF,  32'd2048);
        send_update(32'hFFFF_FFFF,  32'd3248);
        send_update(32'd0,          32'd3348);
        send_update(32'd1,          32'd5348);
        send_update(32'd20001,      32'd6348);
        send_update(32'd40002,      32'd7348);
        send_update(32'd40003,      32'd8347);
        send_update(32'd52347,      32'd9125);
        send_update(32'd52347,      32'hFFFF_FFFF);
        wait_drained();

        set_config(16'd255, wpfm_pkg::ONLY_COUNTER);
        burst_left = 40;
        long_hold_at = cycle_count + 1;
        run_random(500);
        wait_drained();

        set_config(16'd256, wpfm_pkg::ONLY_COUNTER);
        run_random(40);
        wait_drained();

        set_config(16'hFFFF, 8'd0);
        run_random(30);
        wait_drained();

        set_config(16'd0, 8'hFF);
        run_random(30);
        wait_drained();

        set_config(16'd5, 8'd3);
        run_random(20);
        wait_drained();

        set_config(16'd128, wpfm_pkg::ONLY_COUNTER);
        run_random(300);
        wait_drained();
        run_random(300);
        wait_drained();

        set_config(16'hFFFF, wpfm_pkg::ONLY_COUNTER);
        run_random(30);
        wait_drained();

        set_config(16'd0, wpfm_pkg::ONLY_COUNTER);
        run_random(80);
        wait_drained();

        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d readings never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/wpfm_pkg.sv
hw/rtl/wpfm_divider.sv
hw/rtl/windowed_pulse_frequency_meter.sv
tb/windowed_pulse_frequency_meter_tb.sv
